@@ hdl/lfp_pkg.sv @@
// Shared types and constants for the range-sensor frame parser.
// No dependencies.
`default_nettype none

package lfp_pkg;

    localparam logic [7:0]  HEADER_BYTE = 8'h59;
    localparam logic [15:0] LIMIT_RESET = 16'd1000;

    localparam int NUM_DATA = 6;

    typedef logic [3:0] t_pos;

    localparam t_pos POS_HDR0  = 4'd0;
    localparam t_pos POS_HDR1  = 4'd1;
    localparam t_pos POS_DATA0 = 4'd2;
    localparam t_pos POS_CKSUM = 4'd8;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic               done;
        logic               bad;
        logic signed [15:0] distance;
        logic signed [15:0] strength;
        logic signed [15:0] temperature;
    } t_frame_res;

endpackage

`default_nettype wire

@@ hdl/lfp_if.sv @@
// Request and result channel interfaces for the frame parser.
// No dependencies.
`default_nettype none

interface lfp_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] tick_ms;

    modport source (output valid, output req_type, output rx_byte, output tick_ms,
                    input ready);
    modport sink   (input valid, input req_type, input rx_byte, input tick_ms,
                    output ready);
endinterface

interface lfp_res_if;
    logic               valid;
    logic               ready;
    logic               frame_done;
    logic               checksum_bad;
    logic signed [15:0] distance;
    logic signed [15:0] strength;
    logic signed [15:0] temperature;
    logic               offline;

    modport source (output valid, output frame_done, output checksum_bad,
                    output distance, output strength, output temperature,
                    output offline, input ready);
    modport sink   (input valid, input frame_done, input checksum_bad,
                    input distance, input strength, input temperature,
                    input offline, output ready);
endinterface

`default_nettype wire

@@ hdl/lfp_frame.sv @@
// 9-byte frame recognizer: header hunt, running checksum, data latch.
// Depends on lfp_pkg.
`default_nettype none

module lfp_frame (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_byte_en,
    input  wire logic [7:0]        i_byte,
    output lfp_pkg::t_frame_res    o_next
);
    import lfp_pkg::*;

    t_pos               r_pos, n_pos;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_data [NUM_DATA];
    logic signed [15:0] r_dist, r_str, r_temp;
    t_pos               w_pos;
    logic               w_good;

    always_comb begin
        w_pos  = (r_pos > POS_CKSUM) ? POS_HDR0 : r_pos;
        n_pos  = r_pos;
        n_sum  = r_sum;
        w_good = 1'b0;
        o_next.done = 1'b0;
        o_next.bad  = 1'b0;
        if (i_byte_en) begin
            if (w_pos == POS_HDR0 || w_pos == POS_HDR1) begin
                if (i_byte == HEADER_BYTE) begin
                    n_sum = ((w_pos == POS_HDR0) ? 8'd0 : r_sum) + i_byte;
                    n_pos = w_pos + t_pos'(1);
                end else begin
                    n_sum = 8'd0;
                    n_pos = POS_HDR0;
                end
            end else if (w_pos == POS_CKSUM) begin
                w_good      = (r_sum == i_byte);
                o_next.done = w_good;
                o_next.bad  = !w_good;
                n_sum       = 8'd0;
                n_pos       = POS_HDR0;
            end else begin
                n_sum = r_sum + i_byte;
                n_pos = w_pos + t_pos'(1);
            end
        end
        o_next.distance    = w_good ? {r_data[1], r_data[0]} : r_dist;
        o_next.strength    = w_good ? {r_data[3], r_data[2]} : r_str;
        o_next.temperature = w_good ? {r_data[5], r_data[4]} : r_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HDR0;
            r_sum  <= 8'd0;
            r_dist <= '0;
            r_str  <= '0;
            r_temp <= '0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_dist <= o_next.distance;
            r_str  <= o_next.strength;
            r_temp <= o_next.temperature;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_DATA; k++) begin
            if (i_byte_en && w_pos == POS_DATA0 + t_pos'(k)) begin
                r_data[k] <= i_byte;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/lfp_timeout.sv @@
// Silence counter and offline flag driven by time ticks and good frames.
// Depends on lfp_pkg.
`default_nettype none

module lfp_timeout (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_tick_en,
    input  wire logic [7:0]  i_tick_ms,
    input  wire logic        i_frame_good,
    input  wire logic [15:0] i_limit,
    output logic             o_offline_next
);
    import lfp_pkg::*;

    logic [15:0] r_count, n_count;
    logic        r_offline;
    logic [16:0] w_sum;

    always_comb begin
        w_sum          = {1'b0, r_count} + {9'd0, i_tick_ms};
        n_count        = r_count;
        o_offline_next = r_offline;
        if (i_frame_good) begin
            n_count        = 16'd0;
            o_offline_next = 1'b0;
        end else if (i_tick_en) begin
            if (r_count < i_limit) begin
                n_count = w_sum[16] ? 16'hFFFF : w_sum[15:0];
            end else begin
                o_offline_next = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 16'd0;
            r_offline <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_offline <= o_offline_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lidar_frame_parser_with_timeout_core.sv @@
// Range-sensor frame parser with silence timeout, top level.
// Depends on lfp_pkg, lfp_if, lfp_frame, lfp_timeout.
//
// Takes one request per cycle (received byte or time tick) while the output
// register is empty or being drained in the same cycle, and returns one
// result per request, from that register, in the cycle after acceptance.
// Results carry the latched distance, strength and temperature of the last
// good frame, frame_done / checksum_bad for the request's byte, and the
// offline flag. The offline limit is written through i_cfg_wr_en /
// i_cfg_wr_data; the user must do so only while idle, as the block does not
// enforce it. The limit resets to 1000 ms.
`default_nettype none

module lidar_frame_parser_with_timeout_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lfp_req_if.sink          i_req,
    lfp_res_if.source        o_res,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);
    import lfp_pkg::*;

    logic [15:0] r_limit_ms;
    logic        w_accept;
    logic        w_byte_en;
    logic        w_tick_en;
    logic        w_offline_next;
    t_frame_res  w_next;
    t_frame_res  r_res;
    logic        r_offline;
    logic        r_valid;

    assign i_req.ready = !r_valid || o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_byte_en   = w_accept && (i_req.req_type == REQ_BYTE);
    assign w_tick_en   = w_accept && (i_req.req_type == REQ_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_ms <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit_ms <= i_cfg_wr_data;
        end
    end

    lfp_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (w_byte_en),
        .i_byte    (i_req.rx_byte),
        .o_next    (w_next)
    );

    lfp_timeout u_timeout (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_en      (w_tick_en),
        .i_tick_ms      (i_req.tick_ms),
        .i_frame_good   (w_next.done),
        .i_limit        (r_limit_ms),
        .o_offline_next (w_offline_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res     <= w_next;
            r_offline <= w_offline_next;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.frame_done   = r_res.done;
    assign o_res.checksum_bad = r_res.bad;
    assign o_res.distance     = r_res.distance;
    assign o_res.strength     = r_res.strength;
    assign o_res.temperature  = r_res.temperature;
    assign o_res.offline      = r_offline;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the range-sensor frame parser core.
// Depends on lfp_pkg, lfp_if and lidar_frame_parser_with_timeout_core.
// Directed table first, then random frame/tick traffic over several offline limits.

module tb_top;
    import lfp_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic               done;
        logic               bad;
        logic signed [15:0] distance;
        logic signed [15:0] strength;
        logic signed [15:0] temperature;
        logic               offline;
    } t_parse_res;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       typed;
        t_parse_res res;
    } t_dir_row;

    localparam t_parse_res NONE_R = '0;
    localparam t_parse_res OFF_R  = '{1'b0, 1'b0, 16'sh0, 16'sh0, 16'sh0, 1'b1};
    localparam t_parse_res GOOD_R = '{1'b1, 1'b0, 16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b0};
    localparam t_parse_res BAD_R  = '{1'b0, 1'b1, 16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b0};

    localparam t_dir_row DIR_TAB [27] = '{
        '{REQ_TICK, 8'h00,       1'b1, NONE_R},
        '{REQ_BYTE, 8'h00,       1'b1, NONE_R},  // not a header
        '{REQ_BYTE, HEADER_BYTE, 1'b0, NONE_R},
        '{REQ_BYTE, 8'h00,       1'b1, NONE_R},  // second header wrong
        '{REQ_TICK, 8'hFF,       1'b0, NONE_R},
        '{REQ_TICK, 8'hFF,       1'b0, NONE_R},
        '{REQ_TICK, 8'hFF,       1'b0, NONE_R},
        '{REQ_TICK, 8'hFF,       1'b1, NONE_R},  // reaches limit, still online
        '{REQ_TICK, 8'hFF,       1'b1, OFF_R},
        '{REQ_BYTE, HEADER_BYTE, 1'b0, NONE_R},
        '{REQ_BYTE, HEADER_BYTE, 1'b0, NONE_R},
        '{REQ_BYTE, 8'h00,       1'b0, NONE_R},
        '{REQ_BYTE, 8'h80,       1'b0, NONE_R},
        '{REQ_BYTE, 8'hFF,       1'b0, NONE_R},
        '{REQ_BYTE, 8'h7F,       1'b0, NONE_R},
        '{REQ_BYTE, 8'hFF,       1'b0, NONE_R},
        '{REQ_BYTE, 8'hFF,       1'b0, NONE_R},
        '{REQ_BYTE, 8'hAE,       1'b1, GOOD_R},
        '{REQ_BYTE, HEADER_BYTE, 1'b0, NONE_R},
        '{REQ_BYTE, HEADER_BYTE, 1'b0, NONE_R},
        '{REQ_BYTE, 8'h01,       1'b0, NONE_R},
        '{REQ_BYTE, 8'h02,       1'b0, NONE_R},
        '{REQ_BYTE, 8'h03,       1'b0, NONE_R},
        '{REQ_BYTE, 8'h04,       1'b0, NONE_R},
        '{REQ_BYTE, 8'h05,       1'b0, NONE_R},
        '{REQ_BYTE, 8'h06,       1'b0, NONE_R},
        '{REQ_BYTE, 8'hC8,       1'b1, BAD_R}    // checksum off by one
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    lfp_req_if req_if ();
    lfp_res_if res_if ();

    lidar_frame_parser_with_timeout_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .o_res         (res_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // parser state as predicted
    t_pos               frame_pos;
    logic [7:0]         frame_sum;
    logic [7:0]         frame_data [NUM_DATA];
    logic [15:0]        silence_ms;
    logic [15:0]        limit_ms;
    logic               sensor_off;
    logic signed [15:0] last_dist;
    logic signed [15:0] last_str;
    logic signed [15:0] last_temp;

    t_parse_res due_results [$];
    int         fail_cnt   = 0;
    int         idle_cnt   = 0;
    int         items_sent = 0;
    bit         calm;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_parse_res frame_parse_step(input logic kind, input logic [7:0] value);
        t_parse_res  r;
        t_pos        p;
        logic [16:0] acc;
        r = '0;
        if (kind == REQ_BYTE) begin
            p = (frame_pos > POS_CKSUM) ? POS_HDR0 : frame_pos;
            if (p == POS_HDR0 || p == POS_HDR1) begin
                if (value == HEADER_BYTE) begin
                    frame_sum = ((p == POS_HDR0) ? 8'd0 : frame_sum) + value;
                    frame_pos = p + t_pos'(1);
                end else begin
                    frame_sum = '0;
                    frame_pos = POS_HDR0;
                end
            end else if (p == POS_CKSUM) begin
                if (frame_sum == value) begin
                    last_dist  = {frame_data[1], frame_data[0]};
                    last_str   = {frame_data[3], frame_data[2]};
                    last_temp  = {frame_data[5], frame_data[4]};
                    silence_ms = '0;
                    sensor_off = 1'b0;
                    r.done     = 1'b1;
                end else begin
                    r.bad = 1'b1;
                end
                frame_sum = '0;
                frame_pos = POS_HDR0;
            end else begin
                frame_data[3'(p - POS_DATA0)] = value;
                frame_sum = frame_sum + value;
                frame_pos = p + t_pos'(1);
            end
        end else if (silence_ms < limit_ms) begin
            acc = {1'b0, silence_ms} + {9'd0, value};
            silence_ms = acc[16] ? 16'hFFFF : acc[15:0];
        end else begin
            sensor_off = 1'b1;
        end
        r.distance    = last_dist;
        r.strength    = last_str;
        r.temperature = last_temp;
        r.offline     = sensor_off;
        return r;
    endfunction

    function automatic string res_str(input t_parse_res r);
        return $sformatf("done=%0b bad=%0b dist=%0d str=%0d temp=%0d off=%0b",
                         r.done, r.bad, r.distance, r.strength, r.temperature, r.offline);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic put_req(input logic kind, input logic [7:0] value,
                           input logic typed, input t_parse_res typed_res);
        t_parse_res want;
        while (!calm && $urandom_range(0, 99) < 8) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.rx_byte  <= (kind == REQ_BYTE) ? value : 8'($urandom);
        req_if.tick_ms  <= (kind == REQ_TICK) ? value : 8'($urandom);
        do @(posedge i_clk); while (!req_if.ready);
        want = frame_parse_step(kind, value);
        due_results.push_back(typed ? typed_res : want);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input bit corrupt, input int unsigned cut);
        logic [7:0] fb [9];
        logic [7:0] sum;
        fb[0] = HEADER_BYTE;
        fb[1] = HEADER_BYTE;
        sum   = '0;
        for (int k = 0; k < 8; k++) begin
            if (k >= 2)
                fb[k] = pick_byte();
            sum = sum + fb[k];
        end
        fb[8] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (int k = 0; k < cut; k++) begin
            if ($urandom_range(0, 99) < 5)
                put_req(REQ_TICK, 8'($urandom), 1'b0, NONE_R);
            put_req(REQ_BYTE, fb[k], 1'b0, NONE_R);
        end
    endtask

    task automatic send_burst(input bit heavy);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (heavy) begin
            if (pick < 90)
                put_req(REQ_TICK, (pick < 45) ? 8'hFF : 8'($urandom), 1'b0, NONE_R);
            else
                put_req(REQ_BYTE, 8'($urandom), 1'b0, NONE_R);
        end else if (pick < 55) begin
            send_frame(1'b0, 9);
        end else if (pick < 67) begin
            send_frame(1'b1, 9);
        end else if (pick < 80) begin
            send_frame(1'b0, $urandom_range(1, 8));
            put_req(REQ_BYTE, pick_byte(), 1'b0, NONE_R);
        end else begin
            repeat ($urandom_range(1, 4))
                put_req(REQ_TICK, 8'($urandom), 1'b0, NONE_R);
        end
    endtask

    // sender holds off until the pipe is empty, then writes the limit
    task automatic write_limit(input logic [15:0] lim);
        req_if.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        limit_ms = lim;
    endtask

    always @(negedge i_clk)
        res_if.ready <= calm || ($urandom_range(0, 99) >= 8);

    always @(posedge i_clk) begin : chk
        t_parse_res got;
        t_parse_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.frame_done, res_if.checksum_bad, res_if.distance,
                    res_if.strength, res_if.temperature, res_if.offline};
            if (due_results.size() == 0) begin
                if (fail_cnt < MAX_SHOWN)
                    $display("unexpected result: %s", res_str(got));
                fail_cnt++;
            end else begin
                want = due_results.pop_front();
                if (got !== want) begin
                    if (fail_cnt < MAX_SHOWN)
                        $display("mismatch: expected %s, got %s", res_str(want), res_str(got));
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_BYTE;
        req_if.rx_byte  = '0;
        req_if.tick_ms  = '0;
        res_if.ready    = 1'b0;
        calm            = 1'b0;

        frame_pos  = POS_HDR0;
        frame_sum  = '0;
        silence_ms = '0;
        limit_ms   = LIMIT_RESET;
        sensor_off = 1'b0;
        last_dist  = '0;
        last_str   = '0;
        last_temp  = '0;
        foreach (frame_data[k])
            frame_data[k] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TAB[r])
            put_req(DIR_TAB[r].kind, DIR_TAB[r].value, DIR_TAB[r].typed, DIR_TAB[r].res);

        for (int ph = 0; ph < 6; ph++) begin : phase_blk
            int unsigned n;
            logic [15:0] lim;
            bit          heavy;
            heavy = 1'b0;
            calm  = 1'b0;
            n     = 150;
            case (ph)
                0:       lim = 16'd0;
                1:       lim = 16'd1;
                2: begin
                    // long tick run to saturate the silence counter
                    lim   = 16'hFFFF;
                    heavy = 1'b1;
                    n     = 450;
                end
                3: begin
                    lim  = 16'd65000;
                    calm = 1'b1;
                end
                4:       lim = 16'($urandom_range(1, 3000));
                default: lim = 16'($urandom);
            endcase
            write_limit(lim);
            n = n + items_sent;
            while (items_sent < n)
                send_burst(heavy);
        end

        req_if.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
